/* hdl/assert_macros.svh */
// assertion helpers, compiled out with ASSERT_OFF
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`endif
`endif

/* hdl/slrb_pkg.sv */
package slrb_pkg;

    localparam int MAX_LAYERS_DEF = 1024;
    localparam logic [10:0] LAYER_COUNT_RESET = 11'd32;

    localparam logic [25:0] R_GROUND_SQ = 26'd40449600;
    localparam logic [19:0] SHELL_SPAN_SQ = 20'd766800;
    localparam logic [44:0] OFFSET_BOTTOM_Q32 = 45'd42949673;
    localparam logic [44:0] OFFSET_TOP_Q32 = 45'd4294967;
    localparam logic [44:0] R_TOP_Q32 = 45'(6420) << 32;
    localparam logic [44:0] R_GROUND_Q32 = 45'(6360) << 32;

    function automatic logic [41:0] span_root();
        logic [127:0] x;
        logic [127:0] sq;
        logic [63:0] res;
        logic [63:0] c;
        x = 128'(SHELL_SPAN_SQ) << 64;
        res = '0;
        for (int b = 47; b >= 0; b--)
        begin
            c = res | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= x)
            begin
                res = c;
            end
        end
        return res[41:0];
    endfunction

    localparam logic [41:0] SPAN_Q32 = span_root();

endpackage

/* hdl/slrb_div.sv */
module slrb_div #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 22,
    parameter int Q_W = 33,
    parameter int SIDE_W = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);

    logic [Q_W-1:0]    v_reg;
    logic [DEN_W-1:0]  rem_reg [Q_W];
    logic [Q_W-1:0]    nq_reg [Q_W];
    logic [DEN_W-1:0]  den_reg [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    logic [Q_W-1:0]    v_src;
    logic [DEN_W-1:0]  rem_src [Q_W];
    logic [Q_W-1:0]    nq_src [Q_W];
    logic [DEN_W-1:0]  den_src [Q_W];
    logic [SIDE_W-1:0] side_src [Q_W];
    logic [DEN_W:0]    cur [Q_W];
    logic [Q_W-1:0]    ge;
    logic [DEN_W-1:0]  rem_next [Q_W];
    logic [Q_W-1:0]    nq_next [Q_W];

    // one quotient bit per stage
    always_comb
    begin
        for (int s = 0; s < Q_W; s++)
        begin
            if (s == 0)
            begin
                v_src[s] = in_valid;
                rem_src[s] = DEN_W'(num >> Q_W);
                nq_src[s] = num[Q_W-1:0];
                den_src[s] = den;
                side_src[s] = side_in;
            end
            else
            begin
                v_src[s] = v_reg[s-1];
                rem_src[s] = rem_reg[s-1];
                nq_src[s] = nq_reg[s-1];
                den_src[s] = den_reg[s-1];
                side_src[s] = side_reg[s-1];
            end
            cur[s] = {rem_src[s], nq_src[s][Q_W-1]};
            ge[s] = cur[s] >= {1'b0, den_src[s]};
            rem_next[s] = ge[s] ? DEN_W'(cur[s] - {1'b0, den_src[s]}) : DEN_W'(cur[s]);
            nq_next[s] = {nq_src[s][Q_W-2:0], ge[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_src;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                nq_reg[s] <= nq_next[s];
                den_reg[s] <= den_src[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign quo = nq_reg[Q_W-1];
    assign side_out = side_reg[Q_W-1];

endmodule

/* hdl/slrb_sqrt.sv */
module slrb_sqrt #(
    parameter int OUT_W = 45,
    parameter int IN_W = 2 * OUT_W,
    parameter int SIDE_W = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   rad,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [OUT_W-1:0]  root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int RW = OUT_W + 2;

    logic [OUT_W-1:0]  v_reg;
    logic [RW-1:0]     rem_reg [OUT_W];
    logic [OUT_W-1:0]  root_reg [OUT_W];
    logic [IN_W-1:0]   rad_reg [OUT_W];
    logic [SIDE_W-1:0] side_reg [OUT_W];

    logic [OUT_W-1:0]  v_src;
    logic [RW-1:0]     rem_src [OUT_W];
    logic [OUT_W-1:0]  root_src [OUT_W];
    logic [IN_W-1:0]   rad_src [OUT_W];
    logic [SIDE_W-1:0] side_src [OUT_W];
    logic [RW:0]       cur [OUT_W];
    logic [RW:0]       trial [OUT_W];
    logic [OUT_W-1:0]  ge;
    logic [RW-1:0]     rem_next [OUT_W];
    logic [OUT_W-1:0]  root_next [OUT_W];

    // one root bit per stage, two radicand bits consumed
    always_comb
    begin
        for (int s = 0; s < OUT_W; s++)
        begin
            if (s == 0)
            begin
                v_src[s] = in_valid;
                rem_src[s] = '0;
                root_src[s] = '0;
                rad_src[s] = rad;
                side_src[s] = side_in;
            end
            else
            begin
                v_src[s] = v_reg[s-1];
                rem_src[s] = rem_reg[s-1];
                root_src[s] = root_reg[s-1];
                rad_src[s] = rad_reg[s-1];
                side_src[s] = side_reg[s-1];
            end
            cur[s] = {rem_src[s][RW-2:0], rad_src[s][IN_W-1 -: 2]};
            trial[s] = {1'b0, root_src[s], 2'b01};
            ge[s] = cur[s] >= trial[s];
            rem_next[s] = ge[s] ? RW'(cur[s] - trial[s]) : RW'(cur[s]);
            root_next[s] = {root_src[s][OUT_W-2:0], ge[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_src;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < OUT_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                root_reg[s] <= root_next[s];
                rad_reg[s] <= rad_src[s] << 2;
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_valid = v_reg[OUT_W-1];
    assign root = root_reg[OUT_W-1];
    assign side_out = side_reg[OUT_W-1];

endmodule

/* hdl/scatter_layer_radius_bounds.sv */
// throughput: one word per cycle; the whole pipeline holds while a valid result is stalled
// the pipeline runs through the 33-stage divider and the 45- and 42-stage square root pipelines
// reset: layer_count is 32, the pipeline is empty and no result is valid
`include "assert_macros.svh"
module scatter_layer_radius_bounds
    import slrb_pkg::*;
#(
    parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] layer_count,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [9:0]  layer_index,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [28:0] shell_radius,
    output logic [21:0] top_min_distance,
    output logic [26:0] top_max_distance,
    output logic [21:0] ground_min_distance,
    output logic [25:0] ground_max_distance,
    output logic        index_clamped
);

    localparam logic [16:0] MAX_L = 17'(MAX_LAYERS);

    logic en;
    logic [10:0] layer_count_reg;

    logic [10:0] n_nz, n_eff, nm1, d;
    logic        clamp;
    logic [9:0]  l_eff;

    logic        v_s0_reg;
    logic [52:0] num_reg;
    logic [21:0] dd_reg;
    logic [2:0]  flags_reg;

    logic        div_v;
    logic [32:0] t_q;
    logic [2:0]  div_flags;

    logic        v_m1_reg, v_m2_reg;
    logic [52:0] prod_reg;
    logic [57:0] r2_reg;
    logic [2:0]  flags_m1_reg, flags_m2_reg;

    logic        sq1_v;
    logic [44:0] r_raw;
    logic [2:0]  sq1_flags;

    logic        v_a_reg, v_b_reg, v_c_reg, v_d_reg;
    logic [44:0] r_a_reg, r_b_reg, r_c_reg, r_d_reg;
    logic        cl_a_reg, cl_b_reg, cl_c_reg, cl_d_reg;
    logic [41:0] p11_reg;
    logic [44:0] p10_reg;
    logic [47:0] p00_reg;
    logic [89:0] sq_reg;
    logic [83:0] arg_reg;

    logic        sq2_v;
    logic [41:0] rho;
    logic [45:0] sq2_side;

    logic        v_f1_reg;
    logic [44:0] r_f1_reg, top_min_reg, ground_min_reg;
    logic [42:0] top_max_reg;
    logic [41:0] rho_f1_reg;
    logic        cl_f1_reg;

    logic [45:0] rnd_r, rnd_tmin, rnd_gmin;
    logic [43:0] rnd_tmax;
    logic [42:0] rnd_rho;

    logic        v_f2_reg;
    logic [28:0] shell_reg;
    logic [21:0] tmin_reg, gmin_reg;
    logic [26:0] tmax_reg;
    logic [25:0] gmax_reg;
    logic        cl_f2_reg;

    assign en = !v_f2_reg || !result_stall;
    assign item_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg <= LAYER_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            layer_count_reg <= layer_count;
        end
    end

    // layer count and index saturation
    always_comb
    begin
        n_nz = (layer_count_reg == 11'd0) ? 11'd1 : layer_count_reg;
        n_eff = ({6'd0, n_nz} > MAX_L) ? MAX_L[10:0] : n_nz;
        nm1 = n_eff - 11'd1;
        clamp = {1'b0, layer_index} > nm1;
        l_eff = clamp ? nm1[9:0] : layer_index;
        d = (n_eff > 11'd1) ? nm1 : 11'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s0_reg <= 1'b0;
            v_m1_reg <= 1'b0;
            v_m2_reg <= 1'b0;
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
            v_f1_reg <= 1'b0;
            v_f2_reg <= 1'b0;
        end
        else if (en)
        begin
            v_s0_reg <= item_valid;
            v_m1_reg <= div_v;
            v_m2_reg <= v_m1_reg;
            v_a_reg <= sq1_v;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
            v_d_reg <= v_c_reg;
            v_f1_reg <= sq2_v;
            v_f2_reg <= v_f1_reg;
        end
    end

    // flags: clamped, bottom layer, top layer
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg <= 22'(d * d);
            num_reg <= {1'b0, 20'(l_eff * l_eff), 32'd0} + 53'(22'(d * d) >> 1);
            flags_reg <= {clamp, l_eff == 10'd0, {1'b0, l_eff} == nm1};
        end
    end

    slrb_div #(
        .NUM_W  (53),
        .DEN_W  (22),
        .Q_W    (33),
        .SIDE_W (3)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_s0_reg),
        .num       (num_reg),
        .den       (dd_reg),
        .side_in   (flags_reg),
        .out_valid (div_v),
        .quo       (t_q),
        .side_out  (div_flags)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 53'(t_q) * 53'(SHELL_SPAN_SQ);
            flags_m1_reg <= div_flags;
            r2_reg <= (58'(R_GROUND_SQ) << 32) + 58'(prod_reg);
            flags_m2_reg <= flags_m1_reg;
        end
    end

    slrb_sqrt #(
        .OUT_W  (45),
        .IN_W   (90),
        .SIDE_W (3)
    ) u_sqrt_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_m2_reg),
        .rad       ({r2_reg, 32'd0}),
        .side_in   (flags_m2_reg),
        .out_valid (sq1_v),
        .root      (r_raw),
        .side_out  (sq1_flags)
    );

    // layer offsets, then r squared in partial products, then r squared less ground squared
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sq1_flags[1])
            begin
                r_a_reg <= r_raw + OFFSET_BOTTOM_Q32;
            end
            else if (sq1_flags[0])
            begin
                r_a_reg <= r_raw - OFFSET_TOP_Q32;
            end
            else
            begin
                r_a_reg <= r_raw;
            end
            cl_a_reg <= sq1_flags[2];

            p11_reg <= 42'(r_a_reg[44:24]) * 42'(r_a_reg[44:24]);
            p10_reg <= 45'(r_a_reg[44:24]) * 45'(r_a_reg[23:0]);
            p00_reg <= 48'(r_a_reg[23:0]) * 48'(r_a_reg[23:0]);
            r_b_reg <= r_a_reg;
            cl_b_reg <= cl_a_reg;

            sq_reg <= (90'(p11_reg) << 48) + (90'(p10_reg) << 25) + 90'(p00_reg);
            r_c_reg <= r_b_reg;
            cl_c_reg <= cl_b_reg;

            if (sq_reg[89:64] >= R_GROUND_SQ)
            begin
                arg_reg <= 84'(sq_reg - (90'(R_GROUND_SQ) << 64));
            end
            else
            begin
                arg_reg <= '0;
            end
            r_d_reg <= r_c_reg;
            cl_d_reg <= cl_c_reg;
        end
    end

    slrb_sqrt #(
        .OUT_W  (42),
        .IN_W   (84),
        .SIDE_W (46)
    ) u_sqrt_rho (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_d_reg),
        .rad       (arg_reg),
        .side_in   ({cl_d_reg, r_d_reg}),
        .out_valid (sq2_v),
        .root      (rho),
        .side_out  (sq2_side)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_f1_reg <= sq2_side[44:0];
            cl_f1_reg <= sq2_side[45];
            rho_f1_reg <= rho;
            top_min_reg <= (sq2_side[44:0] < R_TOP_Q32) ? R_TOP_Q32 - sq2_side[44:0] : '0;
            ground_min_reg <= (sq2_side[44:0] > R_GROUND_Q32) ?
                sq2_side[44:0] - R_GROUND_Q32 : '0;
            top_max_reg <= 43'(rho) + 43'(SPAN_Q32);
        end
    end

    // round half up from 32 to 16 fraction bits: shell q13.16, min distances q6.16, top max q11.16, ground max q10.16
    always_comb
    begin
        rnd_r = {1'b0, r_f1_reg} + 46'd32768;
        rnd_tmin = {1'b0, top_min_reg} + 46'd32768;
        rnd_gmin = {1'b0, ground_min_reg} + 46'd32768;
        rnd_tmax = {1'b0, top_max_reg} + 44'd32768;
        rnd_rho = {1'b0, rho_f1_reg} + 43'd32768;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shell_reg <= rnd_r[44:16];
            tmin_reg <= rnd_tmin[37:16];
            gmin_reg <= rnd_gmin[37:16];
            tmax_reg <= rnd_tmax[42:16];
            gmax_reg <= rnd_rho[41:16];
            cl_f2_reg <= cl_f1_reg;
        end
    end

    assign result_valid = v_f2_reg;
    assign shell_radius = shell_reg;
    assign top_min_distance = tmin_reg;
    assign top_max_distance = tmax_reg;
    assign ground_min_distance = gmin_reg;
    assign ground_max_distance = gmax_reg;
    assign index_clamped = cl_f2_reg;

    `ASSERT_IMPLY(a_stall_only_on_hold, clk, rst_n, !result_stall, !item_stall)
    `ASSERT_IMPLY(a_radius_above_ground, clk, rst_n, result_valid,
        shell_radius >= 29'd416808960)
    `ASSERT_IMPLY(a_top_max_covers_rho, clk, rst_n, result_valid,
        top_max_distance >= {1'b0, ground_max_distance})

endmodule
